### hdl/pts_pkg.sv
package pts_pkg;

  // Fixed field widths of the command and result channels
  localparam int unsigned OPCODE_W      = 2;
  localparam int unsigned PRIO_REQ_W    = 8;
  localparam int unsigned DELAY_TICKS_W = 16;
  localparam int unsigned SLOT_W        = 5;
  localparam int unsigned READY_W       = 32;
  localparam int unsigned TICK_W        = 32;

  // Parameter defaults
  localparam int unsigned NUM_PRIORITIES_DEF = 32;
  localparam int unsigned DELAY_BITS_DEF     = 16;

  typedef enum logic [OPCODE_W-1:0] {
    OP_CREATE = 2'd0,
    OP_DELAY  = 2'd1,
    OP_TICK   = 2'd2,
    OP_SWITCH = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_PICK
  } state_e;

  // Controller -> datapath commands
  typedef struct packed {
    logic load;   // capture the incoming request
    logic exec;   // apply the request to the task state
    logic pick;   // select current slot, load the result register
  } cmd_t;

endpackage

### hdl/pts_if.sv
interface pts_req_if;
  logic                                valid;
  logic                                ready;
  logic [pts_pkg::OPCODE_W-1:0]        opcode;
  logic [pts_pkg::PRIO_REQ_W-1:0]      priority_req;
  logic [pts_pkg::DELAY_TICKS_W-1:0]   delay_ticks;

  modport source (output valid, opcode, priority_req, delay_ticks, input ready);
  modport sink   (input valid, opcode, priority_req, delay_ticks, output ready);
endinterface

interface pts_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [pts_pkg::SLOT_W-1:0]    current_priority;
  logic                          none_ready;
  logic [pts_pkg::READY_W-1:0]   ready_bits;
  logic [pts_pkg::TICK_W-1:0]    ticks_now;

  modport source (output valid, current_priority, none_ready, ready_bits, ticks_now,
                  input ready);
  modport sink   (input valid, current_priority, none_ready, ready_bits, ticks_now,
                  output ready);
endinterface

### hdl/pts_ctrl.sv
module pts_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output pts_pkg::cmd_t cmd_o
);

  pts_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pts_pkg::S_IDLE: begin
        if (in_valid_i) state_d = pts_pkg::S_EXEC;
      end
      pts_pkg::S_EXEC: begin
        state_d = pts_pkg::S_PICK;
      end
      pts_pkg::S_PICK: begin
        if (out_free) state_d = in_valid_i ? pts_pkg::S_EXEC : pts_pkg::S_IDLE;
      end
      default: state_d = pts_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      pts_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      pts_pkg::S_EXEC: begin
        cmd_o.exec = 1'b1;
      end
      pts_pkg::S_PICK: begin
        cmd_o.pick = out_free;
        in_ready_o = out_free;
        cmd_o.load = out_free && in_valid_i;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.pick) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pts_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### hdl/pts_dp.sv
module pts_dp #(
  parameter int unsigned NumPriorities = pts_pkg::NUM_PRIORITIES_DEF,
  parameter int unsigned DelayBits     = pts_pkg::DELAY_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pts_pkg::cmd_t                       cmd_i,
  input  logic [pts_pkg::OPCODE_W-1:0]        opcode_i,
  input  logic [pts_pkg::PRIO_REQ_W-1:0]      priority_req_i,
  input  logic [pts_pkg::DELAY_TICKS_W-1:0]   delay_ticks_i,
  output logic [pts_pkg::SLOT_W-1:0]          current_priority_o,
  output logic                                none_ready_o,
  output logic [pts_pkg::READY_W-1:0]         ready_bits_o,
  output logic [pts_pkg::TICK_W-1:0]          ticks_now_o
);

  // captured request
  pts_pkg::op_e                       op_q;
  logic [pts_pkg::PRIO_REQ_W-1:0]     preq_q;
  logic [DelayBits-1:0]               dly_q;
  logic                               was_create_q;

  // task state
  logic [NumPriorities-1:0]           ready_q, ready_d;
  logic [NumPriorities-1:0]           used_q, used_d;
  logic [DelayBits-1:0]               delay_q [NumPriorities];
  logic [DelayBits-1:0]               delay_d [NumPriorities];
  logic [pts_pkg::SLOT_W-1:0]         cur_q, cur_d;
  logic                               has_cur_q, has_cur_d;
  logic [pts_pkg::TICK_W-1:0]         ticks_q, ticks_d;

  logic [pts_pkg::SLOT_W-1:0]         new_slot;
  logic [pts_pkg::SLOT_W-1:0]         pick_slot;
  logic                               pick_found;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= pts_pkg::op_e'(opcode_i);
      preq_q <= priority_req_i;
      dly_q  <= DelayBits'(delay_ticks_i);
    end
    if (cmd_i.exec) begin
      was_create_q <= (op_q == pts_pkg::OP_CREATE);
    end
  end

  // clamp to top level
  assign new_slot = (preq_q >= pts_pkg::PRIO_REQ_W'(NumPriorities))
                  ? pts_pkg::SLOT_W'(NumPriorities - 1)
                  : pts_pkg::SLOT_W'(preq_q);

  // priority encoder, highest ready index wins
  always_comb begin
    pick_slot = '0;
    for (int i = 0; i < NumPriorities; i++) begin
      if (ready_q[i]) pick_slot = pts_pkg::SLOT_W'(i);
    end
  end
  assign pick_found = |ready_q;

  always_comb begin
    ready_d   = ready_q;
    used_d    = used_q;
    delay_d   = delay_q;
    cur_d     = cur_q;
    has_cur_d = has_cur_q;
    ticks_d   = ticks_q;
    if (cmd_i.exec) begin
      case (op_q)
        pts_pkg::OP_CREATE: begin
          for (int i = 0; i < NumPriorities; i++) begin
            if (new_slot == pts_pkg::SLOT_W'(i)) begin
              used_d[i]  = 1'b1;
              ready_d[i] = 1'b1;
              delay_d[i] = '0;
            end
          end
          if (!has_cur_q || new_slot >= cur_q) begin
            cur_d     = new_slot;
            has_cur_d = 1'b1;
          end
        end
        pts_pkg::OP_DELAY: begin
          if (has_cur_q && dly_q != '0) begin
            for (int i = 0; i < NumPriorities; i++) begin
              if (cur_q == pts_pkg::SLOT_W'(i)) begin
                delay_d[i] = dly_q;
                ready_d[i] = 1'b0;
              end
            end
          end
        end
        pts_pkg::OP_TICK: begin
          ticks_d = ticks_q + 1'b1;
          for (int i = 0; i < NumPriorities; i++) begin
            if (used_q[i] && delay_q[i] != '0) begin
              delay_d[i] = delay_q[i] - 1'b1;
              if (delay_q[i] == DelayBits'(1)) ready_d[i] = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end else if (cmd_i.pick && !was_create_q && pick_found) begin
      cur_d     = pick_slot;
      has_cur_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q   <= '0;
      used_q    <= '0;
      cur_q     <= '0;
      has_cur_q <= 1'b0;
      ticks_q   <= '0;
      for (int i = 0; i < NumPriorities; i++) delay_q[i] <= '0;
    end else begin
      ready_q   <= ready_d;
      used_q    <= used_d;
      cur_q     <= cur_d;
      has_cur_q <= has_cur_d;
      ticks_q   <= ticks_d;
      delay_q   <= delay_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.pick) begin
      current_priority_o <= cur_d;
      none_ready_o       <= !was_create_q && !pick_found;
      ready_bits_o       <= pts_pkg::READY_W'(ready_q);
      ticks_now_o        <= ticks_q;
    end
  end

endmodule

### hdl/priority_task_scheduler.sv
// Priority task scheduler: one task slot per priority level, tracked by a
// ready bitmap, a used bitmap and a down-counting delay counter per slot.
// Each request (create, delay, tick, switch) yields exactly one response
// with the current slot, a none-ready flag, the ready bitmap and the tick
// count. A request is captured on acceptance; in the apply state it is
// applied to the slot state (all delay counters update in parallel on a
// tick), then the pick state runs the priority encoder over the ready
// bitmap and loads the response register. The next request is accepted
// in that pick cycle, so back-to-back requests overlap as long as the
// response side keeps up; a held response stalls the pick, and with it
// acceptance of the next request, until it is taken.
module priority_task_scheduler #(
  parameter int unsigned NumPriorities = pts_pkg::NUM_PRIORITIES_DEF,
  parameter int unsigned DelayBits     = pts_pkg::DELAY_BITS_DEF
) (
  input logic   clk_i,
  input logic   rst_ni,
  pts_req_if.sink   req_i,
  pts_rsp_if.source rsp_o
);

  pts_pkg::cmd_t cmd;

  // sequencer: accept, apply, pick/respond
  pts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  // slot state, tick counter, priority encoder, response register
  pts_dp #(
    .NumPriorities (NumPriorities),
    .DelayBits     (DelayBits)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .opcode_i           (req_i.opcode),
    .priority_req_i     (req_i.priority_req),
    .delay_ticks_i      (req_i.delay_ticks),
    .current_priority_o (rsp_o.current_priority),
    .none_ready_o       (rsp_o.none_ready),
    .ready_bits_o       (rsp_o.ready_bits),
    .ticks_now_o        (rsp_o.ticks_now)
  );

`ifndef SYNTH
  // an accepted request is applied in the very next cycle
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> cmd.exec)
    else $error("accepted request not applied");

  // every apply cycle is followed by the pick, or by a held response
  a_exec_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.exec |=> (cmd.pick || $stable(rsp_o.valid)))
    else $error("apply not followed by pick");

  // none_ready only when the bitmap is empty
  a_none_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.none_ready) |-> (rsp_o.ready_bits == '0))
    else $error("none_ready with ready bits set");

  // reported slot lies within the configured levels
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (32'(rsp_o.current_priority) < NumPriorities))
    else $error("current slot out of range");
`endif

endmodule

### sim/pts_sched_checker.sv
`timescale 1ns / 1ps

module pts_sched_checker
  import pts_pkg::*;
#(
  parameter int unsigned NumPriorities = NUM_PRIORITIES_DEF,
  parameter int unsigned DelayBits     = DELAY_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  pts_req_if   req_i,
  pts_rsp_if   rsp_i,
  output int   fail_cnt_o,
  output int   pending_o
);

  typedef struct packed {
    logic [SLOT_W-1:0]  current_priority;
    logic               none_ready;
    logic [READY_W-1:0] ready_bits;
    logic [TICK_W-1:0]  ticks_now;
  } sched_view_t;

  // Shadow copy of the scheduler state
  logic [READY_W-1:0]   ready_map;
  logic [READY_W-1:0]   used_map;
  logic [DelayBits-1:0] wait_cnt [NumPriorities];
  logic [SLOT_W-1:0]    cur_slot;
  logic                 cur_valid;
  logic [TICK_W-1:0]    tick_total;

  sched_view_t sched_view_q [$];
  int          mismatch_cnt = 0;

  task automatic flag_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatch_cnt++;
    $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
  endtask

  // Priority encoder over the ready map; keeps current when nothing is ready.
  function automatic bit pick_top();
    bit found;
    found = 1'b0;
    for (int i = NumPriorities - 1; i >= 0; i--) begin
      if (!found && ready_map[i]) begin
        cur_slot  = SLOT_W'(i);
        cur_valid = 1'b1;
        found     = 1'b1;
      end
    end
    return found;
  endfunction

  function automatic sched_view_t apply_command(op_e op, logic [PRIO_REQ_W-1:0] prio,
                                                logic [DELAY_TICKS_W-1:0] dly);
    sched_view_t          view;
    logic [SLOT_W-1:0]    slot;
    logic [DelayBits-1:0] dly_m;
    bit                   none;
    none  = 1'b0;
    dly_m = DelayBits'(dly);
    case (op)
      OP_CREATE: begin
        slot = (prio >= NumPriorities) ? SLOT_W'(NumPriorities - 1) : SLOT_W'(prio);
        used_map[slot]  = 1'b1;
        ready_map[slot] = 1'b1;
        wait_cnt[slot]  = '0;
        if (!cur_valid || slot >= cur_slot) begin
          cur_slot  = slot;
          cur_valid = 1'b1;
        end
      end
      OP_DELAY: begin
        // zero delay is a plain yield: ready bit stays
        if (cur_valid && dly_m != '0) begin
          wait_cnt[cur_slot]  = dly_m;
          ready_map[cur_slot] = 1'b0;
        end
        none = !pick_top();
      end
      OP_TICK: begin
        tick_total = tick_total + 1'b1;
        for (int i = 0; i < NumPriorities; i++) begin
          if (used_map[i] && wait_cnt[i] != '0) begin
            wait_cnt[i] = wait_cnt[i] - 1'b1;
            if (wait_cnt[i] == '0) ready_map[i] = 1'b1;
          end
        end
        none = !pick_top();
      end
      OP_SWITCH: begin
        none = !pick_top();
      end
      default: ;
    endcase
    view.current_priority = cur_slot;
    view.none_ready       = none;
    view.ready_bits       = ready_map;
    view.ticks_now        = tick_total;
    return view;
  endfunction

  always @(posedge clk_i) begin
    sched_view_t want;
    if (!rst_ni) begin
      ready_map  = '0;
      used_map   = '0;
      cur_slot   = '0;
      cur_valid  = 1'b0;
      tick_total = '0;
      for (int i = 0; i < NumPriorities; i++) wait_cnt[i] = '0;
      sched_view_q.delete();
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (sched_view_q.size() == 0) begin
          flag_mismatch("response with no request outstanding", 0, 0);
        end else begin
          want = sched_view_q.pop_front();
          if (rsp_i.current_priority !== want.current_priority)
            flag_mismatch("current_priority", rsp_i.current_priority, want.current_priority);
          if (rsp_i.none_ready !== want.none_ready)
            flag_mismatch("none_ready", rsp_i.none_ready, want.none_ready);
          if (rsp_i.ready_bits !== want.ready_bits)
            flag_mismatch("ready_bits", rsp_i.ready_bits, want.ready_bits);
          if (rsp_i.ticks_now !== want.ticks_now)
            flag_mismatch("ticks_now", rsp_i.ticks_now, want.ticks_now);
        end
      end
      if (req_i.valid && req_i.ready) begin
        sched_view_q.push_back(apply_command(op_e'(req_i.opcode), req_i.priority_req,
                                             req_i.delay_ticks));
      end
    end
    fail_cnt_o <= mismatch_cnt;
    pending_o  <= sched_view_q.size();
  end

endmodule

### sim/tb_priority_task_scheduler.sv
`timescale 1ns / 1ps

// Top of the scheduler bench: clock, reset, request stimulus and response
// back-pressure. All prediction and comparison sit in pts_sched_checker;
// this module only reads its failure and outstanding counts.
module tb_priority_task_scheduler;
  import pts_pkg::*;

  localparam int unsigned NumPriorities = NUM_PRIORITIES_DEF;
  localparam int unsigned DelayBits     = DELAY_BITS_DEF;
  // Watchdog limit, with plenty of headroom over the slowest run.
  localparam int unsigned CycleLimit    = 300000;
  // Extra wait after the outstanding queue drains.
  localparam int unsigned DrainCycles   = 12;
  localparam int unsigned PhaseItems    = 340;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  pts_req_if req_if ();
  pts_rsp_if rsp_if ();

  int          fail_cnt;
  int          pending_cnt;
  int unsigned src_idle_pct  = 0;  // chance per cycle that no request is offered
  int unsigned snk_stall_pct = 0;  // chance per cycle that the response is held off
  int unsigned cycle_cnt     = 0;

  priority_task_scheduler #(
    .NumPriorities(NumPriorities),
    .DelayBits    (DelayBits)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  pts_sched_checker #(
    .NumPriorities(NumPriorities),
    .DelayBits    (DelayBits)
  ) i_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_if),
    .rsp_i     (rsp_if),
    .fail_cnt_o(fail_cnt),
    .pending_o (pending_cnt)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Response back-pressure, re-rolled every cycle so stalls land on any
  // phase of the scheduler's apply and pick states. Held low during reset.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  // Offer one request and hold it until accepted. valid is only dropped
  // when an idle gap actually follows, so it never toggles within a step.
  task automatic send_cmd(op_e op, logic [PRIO_REQ_W-1:0] prio,
                          logic [DELAY_TICKS_W-1:0] dly);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.opcode       <= op;
    req_if.priority_req <= prio;
    req_if.delay_ticks  <= dly;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  // Random traffic. Mostly short delays so parked tasks come back within
  // a few ticks; a few long ones park slots until a create revives them.
  // Unused fields carry random noise on every request.
  task automatic run_random(int unsigned n);
    int unsigned              r;
    op_e                      op;
    logic [PRIO_REQ_W-1:0]    prio;
    logic [DELAY_TICKS_W-1:0] dly;
    for (int unsigned k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 22)      op = OP_CREATE;
      else if (r < 47) op = OP_DELAY;
      else if (r < 85) op = OP_TICK;
      else             op = OP_SWITCH;
      // mostly real levels, sometimes out of range to exercise the clamp
      if ($urandom_range(0, 6) == 0) prio = PRIO_REQ_W'($urandom);
      else                           prio = PRIO_REQ_W'($urandom_range(0, 31));
      case ($urandom_range(0, 9))
        0:       dly = '0;
        1:       dly = DELAY_TICKS_W'($urandom);
        2, 3:    dly = DELAY_TICKS_W'($urandom_range(7, 40));
        default: dly = DELAY_TICKS_W'($urandom_range(1, 6));
      endcase
      send_cmd(op, prio, dly);
    end
  endtask

  initial begin
    req_if.valid        <= 1'b0;
    req_if.opcode       <= OP_SWITCH;
    req_if.priority_req <= '0;
    req_if.delay_ticks  <= '0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, no idling.
    send_cmd(OP_SWITCH, 8'd0,   16'd0);       // pick on empty map: none_ready
    send_cmd(OP_DELAY,  8'd0,   16'd5);       // delay with no current task
    send_cmd(OP_TICK,   8'd0,   16'd0);       // tick on empty scheduler
    send_cmd(OP_CREATE, 8'd0,   16'd0);       // first task becomes current
    send_cmd(OP_DELAY,  8'd0,   16'd0);       // zero delay: yield, stays ready
    send_cmd(OP_CREATE, 8'd255, 16'hFFFF);    // clamps to the top level
    send_cmd(OP_CREATE, 8'd31,  16'd0);       // create on a used slot
    send_cmd(OP_CREATE, 8'd5,   16'd0);       // lower level: current stays
    send_cmd(OP_CREATE, 8'd32,  16'd0);       // just past the top: clamp
    send_cmd(OP_DELAY,  8'd0,   16'hFFFF);    // longest delay on top task
    send_cmd(OP_DELAY,  8'd0,   16'd3);
    send_cmd(OP_DELAY,  8'd0,   16'd1);       // last ready task parked: none_ready
    send_cmd(OP_TICK,   8'd0,   16'd0);       // counter hits zero, ready again
    send_cmd(OP_TICK,   8'd0,   16'd0);
    send_cmd(OP_TICK,   8'd0,   16'd0);
    send_cmd(OP_SWITCH, 8'd0,   16'd0);
    send_cmd(OP_CREATE, 8'd128, 16'd0);       // revives the long-parked top slot
    send_cmd(OP_CREATE, 8'hAA,  16'h5555);
    send_cmd(OP_CREATE, 8'h55,  16'hAAAA);
    send_cmd(OP_DELAY,  8'd0,   16'd2);
    send_cmd(OP_DELAY,  8'd0,   16'h8000);
    send_cmd(OP_DELAY,  8'd0,   16'h00FF);    // empty map again
    send_cmd(OP_SWITCH, 8'd0,   16'd0);
    send_cmd(OP_TICK,   8'd0,   16'd0);
    send_cmd(OP_TICK,   8'd0,   16'd0);

    // Random part in idling phases.
    src_idle_pct = 0;  snk_stall_pct = 0;  run_random(PhaseItems);
    src_idle_pct = 78; snk_stall_pct = 0;  run_random(PhaseItems);
    src_idle_pct = 0;  snk_stall_pct = 78; run_random(PhaseItems);
    src_idle_pct = 32; snk_stall_pct = 32; run_random(PhaseItems);

    req_if.valid <= 1'b0;
    // let the last request show up in the outstanding count before polling it
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
